@@ rtl/plfg_pkg.sv @@
`default_nettype none
package plfg_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_FADE_IN  = 2'd1,
    CMD_FADE_OUT = 2'd2,
    CMD_PLAY     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_PLAYING  = 2'd0,
    ST_PAUSED   = 2'd1,
    ST_SILENCE  = 2'd2,
    ST_FINISHED = 2'd3
  } play_st_t;

  typedef enum logic [1:0] {
    FM_NONE = 2'd0,
    FM_UP   = 2'd1,
    FM_DOWN = 2'd2
  } fade_mode_t;

  localparam logic [1:0] ACT_STOP    = 2'd0;
  localparam logic [1:0] ACT_PAUSE   = 2'd1;
  localparam logic [1:0] ACT_SILENCE = 2'd2;

  // what a request turns into
  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_DIRECT = 2'd1,
    K_SCALED = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_CHECK = 3'd1,
    S_MUL   = 3'd2,
    S_DIV   = 3'd3,
    S_FIX   = 3'd4,
    S_OUT   = 3'd5
  } ctl_st_t;

  typedef struct packed {
    logic ld;
    logic mul;
    logic step;
    logic fix;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/pcm_linear_fade_gain_core.sv @@
// a scaled sample is offered in S_OUT after S_CHECK, S_MUL, S_DIV and S_FIX;
// an unscaled or zero sample after S_CHECK; other commands and dropped samples return to idle with no output
// one request at a time: in_ready is high only in idle; the shift-subtract
// divider produces one quotient bit per cycle
// reset: synchronous active-low rst_n clears the controller and fade state
`default_nettype none
module pcm_linear_fade_gain_core #(
  parameter int LENGTH_BITS = plfg_pkg::LENGTH_BITS_DEF,
  parameter int SAMPLE_BITS = plfg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_command,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic [LENGTH_BITS-1:0]        in_fade_length,
  input  wire logic [1:0]                    in_end_action,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic [1:0]                         out_status,
  output logic                               out_finished_event
);

  plfg_pkg::dp_cmd_t  cmd;
  plfg_pkg::dp_stat_t stat;

  plfg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plfg_dp #(
    .LENGTH_BITS (LENGTH_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_command         (in_command),
    .in_sample          (in_sample),
    .in_fade_length     (in_fade_length),
    .in_end_action      (in_end_action),
    .out_sample_out     (out_sample_out),
    .out_status         (out_status),
    .out_finished_event (out_finished_event)
  );

endmodule
`default_nettype wire

@@ rtl/plfg_ctrl.sv @@
`default_nettype none
module plfg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire plfg_pkg::dp_stat_t stat,
  output plfg_pkg::dp_cmd_t       cmd
);

  plfg_pkg::ctl_st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plfg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      plfg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld    = 1'b1;
          state_nxt = plfg_pkg::S_CHECK;
        end
      end
      plfg_pkg::S_CHECK: begin
        unique case (stat.kind)
          plfg_pkg::K_DIRECT: state_nxt = plfg_pkg::S_OUT;
          plfg_pkg::K_SCALED: state_nxt = plfg_pkg::S_MUL;
          default:            state_nxt = plfg_pkg::S_IDLE;
        endcase
      end
      plfg_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = plfg_pkg::S_DIV;
      end
      plfg_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = plfg_pkg::S_FIX;
        end
      end
      plfg_pkg::S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = plfg_pkg::S_OUT;
      end
      plfg_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = plfg_pkg::S_IDLE;
        end
      end
      default: state_nxt = plfg_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/plfg_dp.sv @@
`default_nettype none
module plfg_dp #(
  parameter int LENGTH_BITS = plfg_pkg::LENGTH_BITS_DEF,
  parameter int SAMPLE_BITS = plfg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire plfg_pkg::dp_cmd_t             cmd,
  output plfg_pkg::dp_stat_t                 stat,
  input  wire logic [1:0]                    in_command,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic [LENGTH_BITS-1:0]        in_fade_length,
  input  wire logic [1:0]                    in_end_action,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic [1:0]                         out_status,
  output logic                               out_finished_event
);

  localparam int LB = LENGTH_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + LB;
  localparam int CW = $clog2(SB);

  // fade state
  plfg_pkg::play_st_t   st_r, st_nxt;
  plfg_pkg::fade_mode_t fm_r, fm_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic [LB-1:0]        pos_r, pos_nxt;
  logic [LB-1:0]        end_r, end_nxt;

  // per-request datapath
  plfg_pkg::kind_t kind_r, kind_nxt;
  logic            neg_r;
  logic [SB-1:0]   mag_r;
  logic [LB-1:0]   num_r, num_nxt;
  logic [LB-1:0]   rem_r;
  logic [SB-1:0]   quo_r;
  logic [CW-1:0]   cnt_r;
  logic [SB-1:0]   res_r, res_nxt;
  logic            evt_r, evt_nxt;

  logic [SB-1:0]   smp_u;
  logic [SB-1:0]   mag_in;
  logic [PW-1:0]   prod;
  logic [LB:0]     trial;
  logic [LB:0]     diff;
  logic            qbit;

  assign smp_u  = SB'(unsigned'(in_sample));
  assign mag_in = smp_u[SB-1] ? (~smp_u + 1'b1) : smp_u;

  always_comb begin
    st_nxt   = st_r;
    fm_nxt   = fm_r;
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    end_nxt  = end_r;
    kind_nxt = plfg_pkg::K_NONE;
    num_nxt  = pos_r;
    res_nxt  = smp_u;
    evt_nxt  = 1'b0;
    unique case (plfg_pkg::cmd_t'(in_command))
      plfg_pkg::CMD_FADE_IN: begin
        if (fm_r == plfg_pkg::FM_NONE && in_fade_length != '0) begin
          end_nxt = in_fade_length;
          pos_nxt = '0;
          fm_nxt  = plfg_pkg::FM_UP;
          st_nxt  = plfg_pkg::ST_PLAYING;
        end
      end
      plfg_pkg::CMD_FADE_OUT: begin
        if (fm_r == plfg_pkg::FM_NONE) begin
          end_nxt  = in_fade_length;
          pos_nxt  = '0;
          fm_nxt   = plfg_pkg::FM_DOWN;
          pend_nxt = in_end_action;
        end
      end
      plfg_pkg::CMD_PLAY: st_nxt = plfg_pkg::ST_PLAYING;
      default: begin
        // samples are dropped while finished or silenced
        if (st_r != plfg_pkg::ST_FINISHED && st_r != plfg_pkg::ST_SILENCE) begin
          kind_nxt = plfg_pkg::K_DIRECT;
          if (fm_r != plfg_pkg::FM_NONE) begin
            if (pos_r >= end_r) begin
              if (fm_r != plfg_pkg::FM_UP) begin
                res_nxt = '0;
                unique case (pend_r)
                  plfg_pkg::ACT_STOP: begin
                    st_nxt  = plfg_pkg::ST_FINISHED;
                    evt_nxt = 1'b1;
                  end
                  plfg_pkg::ACT_PAUSE:   st_nxt = plfg_pkg::ST_PAUSED;
                  plfg_pkg::ACT_SILENCE: st_nxt = plfg_pkg::ST_SILENCE;
                  default:               st_nxt = st_r;
                endcase
              end
              fm_nxt = plfg_pkg::FM_NONE;
            end else begin
              kind_nxt = plfg_pkg::K_SCALED;
              num_nxt  = (fm_r == plfg_pkg::FM_UP) ? pos_r : (end_r - pos_r);
            end
            if (pos_r != '1) begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
      end
    endcase
  end

  // one restoring step: remainder stays below the divisor
  assign prod  = PW'(mag_r) * PW'(num_r);
  assign trial = {rem_r, quo_r[SB-1]};
  assign diff  = trial - {1'b0, end_r};
  assign qbit  = ~diff[LB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= plfg_pkg::ST_PLAYING;
      fm_r   <= plfg_pkg::FM_NONE;
      pend_r <= plfg_pkg::ACT_STOP;
      pos_r  <= '0;
      end_r  <= '0;
      kind_r <= plfg_pkg::K_NONE;
    end else if (cmd.ld) begin
      st_r   <= st_nxt;
      fm_r   <= fm_nxt;
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
      end_r  <= end_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      neg_r <= smp_u[SB-1];
      mag_r <= mag_in;
      num_r <= num_nxt;
      res_r <= res_nxt;
      evt_r <= evt_nxt;
    end
    if (cmd.mul) begin
      rem_r <= prod[PW-1:SB];
      quo_r <= prod[SB-1:0];
      cnt_r <= '0;
    end
    if (cmd.step) begin
      rem_r <= qbit ? diff[LB-1:0] : trial[LB-1:0];
      quo_r <= {quo_r[SB-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.fix) begin
      res_r <= neg_r ? (~quo_r + 1'b1) : quo_r;
    end
  end

  assign stat.kind     = kind_r;
  assign stat.div_last = (cnt_r == CW'(SB - 1));

  assign out_sample_out     = res_r;
  assign out_status         = st_r;
  assign out_finished_event = evt_r;

endmodule
`default_nettype wire

@@ verif/pcm_linear_fade_gain_core_test.sv @@
module pcm_linear_fade_gain_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB = plfg_pkg::LENGTH_BITS_DEF;
  localparam int SB = plfg_pkg::SAMPLE_BITS_DEF;

  typedef struct {
    logic signed [SB-1:0] sample;
    plfg_pkg::play_st_t   status;
    logic                 fin_evt;
  } gain_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_command = plfg_pkg::CMD_SAMPLE;
  logic signed [SB-1:0] in_sample = '0;
  logic [LB-1:0]        in_fade_length = '0;
  logic [1:0]           in_end_action = plfg_pkg::ACT_STOP;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SB-1:0] out_sample_out;
  logic [1:0]           out_status;
  logic                 out_finished_event;

  // own copy of the fade state
  plfg_pkg::play_st_t   st_play;
  plfg_pkg::fade_mode_t st_mode;
  logic [1:0]           st_action;
  logic [LB-1:0]        st_pos;
  logic [LB-1:0]        st_end;

  gain_result_t expected_samples[$];
  int           failures = 0;
  int           requests_sent = 0;
  bit           in_gaps_on = 1'b1;
  bit           out_stall_on = 1'b1;

  pcm_linear_fade_gain_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_sample         (in_sample),
    .in_fade_length    (in_fade_length),
    .in_end_action     (in_end_action),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_status        (out_status),
    .out_finished_event(out_finished_event)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SB-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SB-1){1'b0}}};
      1: return {1'b0, {(SB-1){1'b1}}};
      2: return SB'($urandom_range(0, 2)) - SB'(1);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [LB-1:0] random_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return LB'($urandom);
    endcase
  endfunction

  // lengths for fades that actually start; a huge one would never end
  function automatic logic [LB-1:0] short_fade_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LB'($urandom_range(0, 8));
    if (r < 95) return LB'($urandom_range(9, 40));
    return LB'($urandom_range(41, 120));
  endfunction

  function automatic logic [1:0] random_action();
    if ($urandom_range(0, 99) < 15) return 2'd3;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic reset_fade_model();
    st_play   = plfg_pkg::ST_PLAYING;
    st_mode   = plfg_pkg::FM_NONE;
    st_action = plfg_pkg::ACT_STOP;
    st_pos    = '0;
    st_end    = '0;
  endtask

  // update the fade state for one accepted request, queue the sample it yields
  task automatic apply_fade_request(input plfg_pkg::cmd_t cmd,
                                    input logic signed [SB-1:0] smp,
                                    input logic [LB-1:0] len, input logic [1:0] act);
    gain_result_t  r;
    logic [SB:0]   mag;
    logic [SB:0]   q;
    logic [SB+LB:0] prod;
    logic [LB-1:0] num;
    case (cmd)
      plfg_pkg::CMD_FADE_IN: begin
        if (st_mode == plfg_pkg::FM_NONE && len != '0) begin
          st_end  = len;
          st_pos  = '0;
          st_mode = plfg_pkg::FM_UP;
          st_play = plfg_pkg::ST_PLAYING;
        end
      end
      plfg_pkg::CMD_FADE_OUT: begin
        if (st_mode == plfg_pkg::FM_NONE) begin
          st_end    = len;
          st_pos    = '0;
          st_mode   = plfg_pkg::FM_DOWN;
          st_action = act;
        end
      end
      plfg_pkg::CMD_PLAY: begin
        st_play = plfg_pkg::ST_PLAYING;
      end
      default: begin
        if (st_play != plfg_pkg::ST_FINISHED && st_play != plfg_pkg::ST_SILENCE) begin
          r.sample  = smp;
          r.fin_evt = 1'b0;
          if (st_mode != plfg_pkg::FM_NONE) begin
            if (st_pos >= st_end) begin
              if (st_mode == plfg_pkg::FM_DOWN) begin
                r.sample = '0;
                case (st_action)
                  plfg_pkg::ACT_STOP: begin
                    r.fin_evt = (st_play != plfg_pkg::ST_FINISHED);
                    st_play   = plfg_pkg::ST_FINISHED;
                  end
                  plfg_pkg::ACT_PAUSE:   st_play = plfg_pkg::ST_PAUSED;
                  plfg_pkg::ACT_SILENCE: st_play = plfg_pkg::ST_SILENCE;
                  default: ;
                endcase
              end
              st_mode = plfg_pkg::FM_NONE;
            end else begin
              num  = (st_mode == plfg_pkg::FM_UP) ? st_pos : st_end - st_pos;
              mag  = smp[SB-1] ? (SB+1)'(0) - {1'b1, smp} : {1'b0, smp};
              prod = mag * num;
              q    = (SB+1)'(prod / st_end);
              r.sample = smp[SB-1] ? SB'(0) - q[SB-1:0] : q[SB-1:0];
            end
            if (st_pos != '1) st_pos = st_pos + 1'b1;
          end
          r.status = st_play;
          expected_samples.insert(expected_samples.size(), r);
        end
      end
    endcase
  endtask

  task automatic send_request(input plfg_pkg::cmd_t cmd, input logic signed [SB-1:0] smp,
                              input logic [LB-1:0] len, input logic [1:0] act);
    int gap;
    gap = in_gaps_on ? random_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_sample      <= smp;
    in_fade_length <= len;
    in_end_action  <= act;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_fade_request(cmd, smp, len, act);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SB + 8) @(posedge clk);
  endtask

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    gain_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        log_failure($sformatf("unexpected sample %0d status %0d event %0b",
                              out_sample_out, out_status, out_finished_event));
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_out !== want.sample || out_status !== want.status ||
            out_finished_event !== want.fin_evt)
          log_failure($sformatf("expected sample %0d status %0d event %0b, got %0d %0d %0b",
                                want.sample, want.status, want.fin_evt,
                                out_sample_out, out_status, out_finished_event));
      end
    end
  end

  // output backpressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = random_gap();
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 5);
      end
    end
  end

  task automatic test_plain_samples();
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh7fff, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh8000, '1, 2'd3);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh0000, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, -16'sd1, 24'h5a5a5a, plfg_pkg::ACT_PAUSE);
  endtask

  task automatic test_fade_in();
    // zero length is ignored
    send_request(plfg_pkg::CMD_FADE_IN, '0, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_FADE_IN, '0, LB'(3), plfg_pkg::ACT_STOP);
    // busy, ignored
    send_request(plfg_pkg::CMD_FADE_OUT, '0, '1, 2'd3);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh8000, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh7fff, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh8000, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd1000, '0, plfg_pkg::ACT_STOP);
  endtask

  task automatic test_fade_out_actions();
    send_request(plfg_pkg::CMD_FADE_OUT, '0, LB'(2), plfg_pkg::ACT_PAUSE);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh7fff, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh8000, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd5, '0, plfg_pkg::ACT_STOP);
    // paused samples still pass
    send_request(plfg_pkg::CMD_SAMPLE, -16'sd7, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_FADE_OUT, '0, '0, plfg_pkg::ACT_SILENCE);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd1234, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd4321, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_PLAY, '0, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_FADE_OUT, '0, LB'(1), plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sh8000, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd99, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd98, '0, plfg_pkg::ACT_STOP);
    send_request(plfg_pkg::CMD_PLAY, 16'sh5555, 24'haaaaaa, 2'd3);
    // unknown end action leaves the status alone
    send_request(plfg_pkg::CMD_FADE_OUT, '0, '0, 2'd3);
    send_request(plfg_pkg::CMD_SAMPLE, 16'sd77, '0, plfg_pkg::ACT_STOP);
  endtask

  task automatic test_random_stream(input int count);
    int stop_at;
    int next_pause;
    int r;
    int n;
    logic [LB-1:0] len;
    stop_at    = requests_sent + count;
    next_pause = requests_sent + 150;
    while (requests_sent < stop_at) begin
      if (requests_sent >= next_pause) begin
        wait_drained();
        next_pause += 150;
      end
      in_gaps_on   = $urandom_range(0, 4) != 0;
      out_stall_on = $urandom_range(0, 4) != 0;
      r = $urandom_range(0, 99);
      if ((st_play == plfg_pkg::ST_FINISHED || st_play == plfg_pkg::ST_SILENCE) && r < 60) begin
        send_request(plfg_pkg::CMD_PLAY, random_sample(), random_length(), 2'($urandom));
      end else if (r < 80) begin
        len = short_fade_length();
        send_request(($urandom_range(0, 1) != 0) ? plfg_pkg::CMD_FADE_IN
                                                 : plfg_pkg::CMD_FADE_OUT,
                     random_sample(), len, random_action());
        n = int'(len) + $urandom_range(0, 3);
        repeat (n) send_request(plfg_pkg::CMD_SAMPLE, random_sample(), random_length(),
                                2'($urandom));
        if ($urandom_range(0, 2) == 0)
          send_request(plfg_pkg::CMD_PLAY, random_sample(), random_length(), 2'($urandom));
      end else begin
        len = (st_mode == plfg_pkg::FM_NONE) ? short_fade_length() : random_length();
        send_request(plfg_pkg::cmd_t'(2'($urandom_range(0, 3))), random_sample(), len,
                     2'($urandom));
      end
    end
  endtask

  initial begin
    reset_fade_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_samples();
    test_fade_in();
    test_fade_out_actions();
    test_random_stream(620);
    wait_drained();
    if (failures == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
